// ----- src/gregorian_date_add_days_macros.svh -----
// Assertion macros shared by the date stepper checker.
`ifndef GREGORIAN_DATE_ADD_DAYS_MACROS_SVH
`define GREGORIAN_DATE_ADD_DAYS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define GDAD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define GDAD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/gdad_pkg.sv -----
// Shared types, constants and calendar functions for the date stepper.
`default_nettype none
package gdad_pkg;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned WDAY_W   = 3;
    localparam int unsigned OUT_W    = YEAR_W + MONTH_W + DAY_W + WDAY_W + 1;
    localparam int unsigned M_DATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LONG  = 5'd31;
    localparam logic [8:0]         YMOD_LAST = 9'd399;

    // Reciprocals for division by constants (exact over the ranges used)
    localparam logic [13:0] RECIP_400 = 14'd10486;  // y / 400 = (y * R) >> 22
    localparam logic [13:0] RECIP_100 = 14'd5243;   // y / 100 = (y * R) >> 19
    localparam logic [11:0] RECIP_7   = 12'd2341;   // h / 7   = (h * R) >> 14

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture request and sign/magnitude of offset
        logic yr_mul;    // year times reciprocal of 400
        logic yr_mod;    // year modulo 400
        logic step;      // one day step
        logic zel_a;     // Zeller: adjust month/year, century product
        logic zel_b;     // Zeller: century and year of century
        logic zel_c;     // Zeller: congruence sum
        logic zel_d;     // Zeller: sum times reciprocal of 7
        logic out_load;  // finish weekday and load result register
    } gdad_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic steps_done;
    } gdad_sts_t;

    // Leap year from the year modulo 400
    function automatic logic gdad_is_leap(input logic [8:0] ymod);
        logic by4;
        logic by100;
        by4   = (ymod[1:0] == 2'd0);
        by100 = (ymod == 9'd100) || (ymod == 9'd200) || (ymod == 9'd300);
        return (by4 && !by100);
    endfunction

    // Month length, leap-aware
    function automatic logic [DAY_W-1:0] gdad_month_len(input logic leap,
                                                       input logic [MONTH_W-1:0] mon);
        logic [DAY_W-1:0] len;
        unique case (mon)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // Month term of Zeller's congruence: (13 * (m + 1)) / 5 for m in 3..14
    function automatic logic [5:0] gdad_zeller_month(input logic [MONTH_W-1:0] mz);
        logic [5:0] t;
        unique case (mz)
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

// ----- src/gregorian_date_add_days.sv -----
// An accepted request passes the year product and year modulo states, then the step
// loop, one day per cycle over N = days stepped (|offset|, fewer when the year bound stops
// stepping), then the weekday states and DONE, which waits for a free output register and
// loads the result. A new request is taken only after that load, also while a result waits.
// Reset: synchronous, active low; clears the state machine and the result valid flag.
`default_nettype none
module gregorian_date_add_days
    import gdad_pkg::*;
#(
    parameter int unsigned OFFSET_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // s_tdata: start_year[13:0], start_month[17:14], start_day[22:18],
    //          day_offset[22+OFFSET_BITS:23], zero padding above
    input  wire logic [((23 + OFFSET_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // m_tdata: end_year[13:0], end_month[17:14], end_day[22:18], weekday[25:23],
    //          year_clamped[26], zero padding above
    output logic [M_DATA_W-1:0]       m_tdata
);

    localparam int unsigned OFF_LSB = YEAR_W + MONTH_W + DAY_W;

    gdad_cmd_t        cmd;
    gdad_sts_t        sts;
    logic [OUT_W-1:0] out_item;

    gdad_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gdad_dp #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .aclk      (aclk),
        .cmd       (cmd),
        .sts       (sts),
        .in_year   (s_tdata[YEAR_W-1:0]),
        .in_month  (s_tdata[YEAR_W+MONTH_W-1:YEAR_W]),
        .in_day    (s_tdata[OFF_LSB-1:YEAR_W+MONTH_W]),
        .in_offset (s_tdata[OFF_LSB+OFFSET_BITS-1:OFF_LSB]),
        .out_item  (out_item)
    );

    assign m_tdata = {{(M_DATA_W - OUT_W){1'b0}}, out_item};

endmodule
`default_nettype wire

// ----- src/gdad_ctrl.sv -----
// Controller state machine for the date stepper.
`default_nettype none
module gdad_ctrl
    import gdad_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    input  wire gdad_sts_t sts,
    output gdad_cmd_t      cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_YMUL  = 9'b000000010,
        ST_YMOD  = 9'b000000100,
        ST_STEP  = 9'b000001000,
        ST_ZA    = 9'b000010000,
        ST_ZB    = 9'b000100000,
        ST_ZC    = 9'b001000000,
        ST_ZD    = 9'b010000000,
        ST_DONE  = 9'b100000000
    } gdad_state_t;

    gdad_state_t state_reg, state_next;
    logic        mvalid_reg, mvalid_next;
    logic        out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign out_free = !mvalid_reg || m_tready;

    // Sequence the request through load, year modulo, stepping and weekday stages
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_YMUL;
                end
            end
            ST_YMUL: begin
                cmd.yr_mul = 1'b1;
                state_next = ST_YMOD;
            end
            ST_YMOD: begin
                cmd.yr_mod = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                if (sts.steps_done) begin
                    state_next = ST_ZA;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_ZA: begin
                cmd.zel_a  = 1'b1;
                state_next = ST_ZB;
            end
            ST_ZB: begin
                cmd.zel_b  = 1'b1;
                state_next = ST_ZC;
            end
            ST_ZC: begin
                cmd.zel_c  = 1'b1;
                state_next = ST_ZD;
            end
            ST_ZD: begin
                cmd.zel_d  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result valid until taken
    always_comb begin
        mvalid_next = mvalid_reg;
        if (cmd.out_load) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/gdad_dp.sv -----
// Datapath for the date stepper: date registers, day step logic and weekday unit.
`default_nettype none
module gdad_dp
    import gdad_pkg::*;
#(
    parameter int unsigned OFFSET_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire gdad_cmd_t              cmd,
    output gdad_sts_t                   sts,
    input  wire logic [YEAR_W-1:0]      in_year,
    input  wire logic [MONTH_W-1:0]     in_month,
    input  wire logic [DAY_W-1:0]       in_day,
    input  wire logic [OFFSET_BITS-1:0] in_offset,
    output logic [OUT_W-1:0]            out_item
);

    // Date and stepping state
    logic [YEAR_W-1:0]      y_reg, y_next;
    logic [MONTH_W-1:0]     m_reg, m_next;
    logic [DAY_W-1:0]       d_reg, d_next;
    logic [8:0]             ymod_reg, ymod_next;
    logic [OFFSET_BITS-1:0] cnt_reg, cnt_next;
    logic                   back_reg, back_next;
    logic                   clamp_reg, clamp_next;
    logic [26:0]            yprod_reg, yprod_next;

    // Weekday unit state
    logic [YEAR_W-1:0]      zy_reg, zy_next;
    logic [5:0]             zterm_reg, zterm_next;
    logic [26:0]            zprod_reg, zprod_next;
    logic [6:0]             j_reg, j_next;
    logic [6:0]             k_reg, k_next;
    logic [9:0]             h_reg, h_next;
    logic [20:0]            hprod_reg, hprod_next;
    logic [OUT_W-1:0]       out_reg, out_next;

    // Combinational helpers
    logic                   leap;
    logic [DAY_W-1:0]       len_cur;
    logic [DAY_W-1:0]       len_prev;
    logic [MONTH_W-1:0]     m_dec;
    logic [4:0]             q400;
    logic [YEAR_W-1:0]      q400_x;
    logic [YEAR_W-1:0]      ydiff;
    logic                   zwrap;
    logic [YEAR_W-1:0]      zy_c;
    logic [MONTH_W-1:0]     zm_c;
    logic [YEAR_W-1:0]      j100;
    logic [YEAR_W-1:0]      kdiff;
    logic [9:0]             j10;
    logic [6:0]             q7;
    logic [9:0]             q7_x;
    logic [9:0]             rem7;
    logic [WDAY_W-1:0]      wday;

    assign sts.steps_done = (cnt_reg == '0);
    assign out_item       = out_reg;

    assign leap     = gdad_is_leap(ymod_reg);
    assign m_dec    = m_reg - MONTH_JAN;
    assign len_cur  = gdad_month_len(leap, m_reg);
    assign len_prev = (m_reg == MONTH_JAN) ? DAY_LONG : gdad_month_len(leap, m_dec);

    // Year modulo 400 from the registered reciprocal product
    assign q400   = yprod_reg[26:22];
    assign q400_x = {9'd0, q400} * 14'd400;
    assign ydiff  = y_reg - q400_x;

    // Zeller: January and February count as months 13 and 14 of the prior year
    assign zwrap = (m_reg < MONTH_MAR);
    assign zy_c  = zwrap ? (y_reg - YEAR_MIN) : y_reg;
    assign zm_c  = zwrap ? (m_reg + MONTHS_PER_YEAR) : m_reg;

    // Century and year of century
    assign j100  = {7'd0, zprod_reg[25:19]} * 14'd100;
    assign kdiff = zy_reg - j100;
    assign j10   = {3'd0, j_reg};

    // Weekday from the congruence sum, remapped so that Sunday is zero
    assign q7   = hprod_reg[20:14];
    assign q7_x = {3'd0, q7} * 10'd7;
    assign rem7 = h_reg - q7_x;
    assign wday = (rem7[2:0] == 3'd0) ? 3'd6 : (rem7[2:0] - 3'd1);

    // Load the request, find the year modulo 400, then run the date step
    always_comb begin
        y_next     = y_reg;
        m_next     = m_reg;
        d_next     = d_reg;
        ymod_next  = ymod_reg;
        cnt_next   = cnt_reg;
        back_next  = back_reg;
        clamp_next = clamp_reg;
        yprod_next = yprod_reg;
        if (cmd.load) begin
            clamp_next = (in_year < YEAR_MIN) || (in_year > YEAR_MAX);
            if (in_year < YEAR_MIN) begin
                y_next = YEAR_MIN;
            end else if (in_year > YEAR_MAX) begin
                y_next = YEAR_MAX;
            end else begin
                y_next = in_year;
            end
            if (in_month == 4'd0) begin
                m_next = MONTH_JAN;
            end else if (in_month > MONTH_DEC) begin
                m_next = MONTH_DEC;
            end else begin
                m_next = in_month;
            end
            d_next    = in_day;
            back_next = in_offset[OFFSET_BITS-1];
            cnt_next  = in_offset[OFFSET_BITS-1]
                      ? (~in_offset) + {{(OFFSET_BITS-1){1'b0}}, 1'b1}
                      : in_offset;
        end
        if (cmd.yr_mul) begin
            yprod_next = {13'd0, y_reg} * {13'd0, RECIP_400};
        end
        if (cmd.yr_mod) begin
            ymod_next = ydiff[8:0];
        end
        if (cmd.step) begin
            cnt_next = cnt_reg - {{(OFFSET_BITS-1){1'b0}}, 1'b1};
            if (!back_reg) begin
                // Advance one day
                if (d_reg < len_cur) begin
                    d_next = d_reg + DAY_FIRST;
                end else if (m_reg == MONTH_DEC) begin
                    if (y_reg >= YEAR_MAX) begin
                        d_next     = DAY_LONG;
                        clamp_next = 1'b1;
                        cnt_next   = '0;
                    end else begin
                        m_next    = MONTH_JAN;
                        y_next    = y_reg + YEAR_MIN;
                        ymod_next = (ymod_reg == YMOD_LAST) ? 9'd0 : (ymod_reg + 9'd1);
                        d_next    = DAY_FIRST;
                    end
                end else begin
                    m_next = m_reg + MONTH_JAN;
                    d_next = DAY_FIRST;
                end
            end else begin
                // Go back one day
                if (d_reg > DAY_FIRST) begin
                    d_next = d_reg - DAY_FIRST;
                end else if (m_reg == MONTH_JAN) begin
                    if (y_reg <= YEAR_MIN) begin
                        d_next     = DAY_FIRST;
                        clamp_next = 1'b1;
                        cnt_next   = '0;
                    end else begin
                        m_next    = MONTH_DEC;
                        y_next    = y_reg - YEAR_MIN;
                        ymod_next = (ymod_reg == 9'd0) ? YMOD_LAST : (ymod_reg - 9'd1);
                        d_next    = len_prev;
                    end
                end else begin
                    m_next = m_dec;
                    d_next = len_prev;
                end
            end
        end
    end

    // Weekday unit, one stage per command
    always_comb begin
        zy_next    = zy_reg;
        zterm_next = zterm_reg;
        zprod_next = zprod_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        h_next     = h_reg;
        hprod_next = hprod_reg;
        out_next   = out_reg;
        if (cmd.zel_a) begin
            zy_next    = zy_c;
            zterm_next = gdad_zeller_month(zm_c);
            zprod_next = {13'd0, zy_c} * {13'd0, RECIP_100};
        end
        if (cmd.zel_b) begin
            j_next = zprod_reg[25:19];
            k_next = kdiff[6:0];
        end
        if (cmd.zel_c) begin
            h_next = {5'd0, d_reg} + {4'd0, zterm_reg} + {3'd0, k_reg}
                   + {5'd0, k_reg[6:2]} + {5'd0, j_reg[6:2]}
                   + (j10 << 2) + j10;
        end
        if (cmd.zel_d) begin
            hprod_next = {11'd0, h_reg} * {9'd0, RECIP_7};
        end
        if (cmd.out_load) begin
            out_next = {clamp_reg, wday, d_reg, m_reg, y_reg};
        end
    end

    always_ff @(posedge aclk) begin
        y_reg     <= y_next;
        m_reg     <= m_next;
        d_reg     <= d_next;
        ymod_reg  <= ymod_next;
        cnt_reg   <= cnt_next;
        back_reg  <= back_next;
        clamp_reg <= clamp_next;
        yprod_reg <= yprod_next;
        zy_reg    <= zy_next;
        zterm_reg <= zterm_next;
        zprod_reg <= zprod_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        h_reg     <= h_next;
        hprod_reg <= hprod_next;
        out_reg   <= out_next;
    end

endmodule
`default_nettype wire

// ----- src/gdad_chk.sv -----
// Port-level checker for the date stepper, bound to the top level.
`default_nettype none
`include "gregorian_date_add_days_macros.svh"
module gdad_chk
    import gdad_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    // Hold a stalled result
    `GDAD_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // One request in flight: stop accepting right after a request
    `GDAD_ASSERT_NEXT(a_one_inflight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request accepted while busy")

    // Weekday stays in Sunday..Saturday
    `GDAD_ASSERT_NOW(a_wday_range, aclk, aresetn, m_tvalid, m_tdata[25:23] != 3'd7, "weekday out of range")

    // Year and month stay within the calendar bounds
    `GDAD_ASSERT_NOW(a_date_range, aclk, aresetn, m_tvalid, (m_tdata[13:0] != 14'd0) && (m_tdata[13:0] <= 14'd9999) && (m_tdata[17:14] != 4'd0) && (m_tdata[17:14] <= 4'd12), "date out of range")

endmodule

bind gregorian_date_add_days gdad_chk u_gdad_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for the Gregorian date stepper with weekday output.
`timescale 1ns / 1ps

module tb_top;
    import gdad_pkg::*;

    localparam int unsigned OFFSET_BITS = 16;
    localparam int unsigned S_DATA_W    = ((23 + OFFSET_BITS + 7) / 8) * 8;
    localparam int unsigned REQ_W       = YEAR_W + MONTH_W + DAY_W + OFFSET_BITS;
    localparam int unsigned RES_W       = YEAR_W + MONTH_W + DAY_W + WDAY_W + 1;
    localparam int unsigned ITEMS_PER_PHASE = 282;
    localparam int unsigned TAIL_CYCLES     = 64;

    // Request and result layouts, lowest field in the lowest bits
    typedef struct packed {
        logic [OFFSET_BITS-1:0] offset;
        logic [DAY_W-1:0]       day;
        logic [MONTH_W-1:0]     month;
        logic [YEAR_W-1:0]      year;
    } date_request_t;

    typedef struct packed {
        logic               clamped;
        logic [WDAY_W-1:0]  weekday;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    date_request_t pending_requests[$];
    date_result_t  expected_dates[$];
    logic          s_fired = 1'b0;
    int unsigned   sender_idle_pct = 0;
    int unsigned   recv_stall_pct  = 0;
    int unsigned   mismatch_count  = 0;
    longint        cycle_count     = 0;
    longint        cycle_budget    = 0;

    gregorian_date_add_days #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        // s_tdata: start_year, start_month, start_day, day_offset, zero padding
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        // m_tdata: end_year, end_month, end_day, weekday, year_clamped, zero padding
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Month length with the Gregorian leap rule
    function automatic int month_days(input int y, input int m);
        bit leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        case (m)
            2:             return leap ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // Weekday by Zeller's congruence, remapped so that Sunday is zero
    function automatic logic [WDAY_W-1:0] zeller_weekday(input int y, input int m, input int d);
        int k;
        int j;
        int h;
        if (m < 3) begin
            m = m + 12;
            y = y - 1;
        end
        k = y % 100;
        j = y / 100;
        h = (d + (13 * (m + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
        return WDAY_W'((h + 6) % 7);
    endfunction

    // Walk the date one day at a time and work out the resulting date
    function automatic date_result_t advance_date(input date_request_t rq);
        date_result_t res;
        int y;
        int m;
        int d;
        int off;
        int fwd;
        int back;
        bit clamp;
        y     = rq.year;
        m     = rq.month;
        d     = rq.day;
        off   = int'($signed(rq.offset));
        fwd   = (off > 0) ? off : 0;
        back  = (off < 0) ? -off : 0;
        clamp = 1'b0;
        if (m == 0) m = MONTH_JAN;
        if (m > MONTH_DEC) m = MONTH_DEC;
        if (y < YEAR_MIN) begin
            y     = YEAR_MIN;
            clamp = 1'b1;
        end
        if (y > YEAR_MAX) begin
            y     = YEAR_MAX;
            clamp = 1'b1;
        end
        for (int n = 0; n < fwd; n++) begin
            if (d < month_days(y, m)) begin
                d++;
            end else begin
                if (m == MONTH_DEC) begin
                    if (y >= YEAR_MAX) begin
                        d     = 31;
                        clamp = 1'b1;
                        break;
                    end
                    m = MONTH_JAN;
                    y++;
                end else begin
                    m++;
                end
                d = 1;
            end
        end
        for (int n = 0; n < back; n++) begin
            if (d > 1) begin
                d--;
            end else begin
                if (m == MONTH_JAN) begin
                    if (y <= YEAR_MIN) begin
                        d     = 1;
                        clamp = 1'b1;
                        break;
                    end
                    m = MONTH_DEC;
                    y--;
                end else begin
                    m--;
                end
                d = month_days(y, m);
            end
        end
        res.year    = YEAR_W'(y);
        res.month   = MONTH_W'(m);
        res.day     = DAY_W'(d);
        res.weekday = zeller_weekday(y, m, d);
        res.clamped = clamp;
        return res;
    endfunction

    // Queue one request and extend the run budget by its stepping time
    task automatic queue_request(input int y, input int m, input int d, input int off);
        date_request_t rq;
        rq.year   = YEAR_W'(y);
        rq.month  = MONTH_W'(m);
        rq.day    = DAY_W'(d);
        rq.offset = OFFSET_BITS'(off);
        pending_requests = {pending_requests, rq};
        cycle_budget = cycle_budget + ((off < 0) ? -off : off) + 9 + 60;
    endtask

    // Mostly valid dates with short offsets, some noise and rare long walks
    task automatic queue_random_request();
        int y;
        int m;
        int d;
        int off;
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            case ($urandom_range(0, 9))
                0:       y = $urandom_range(1, 3);
                1:       y = $urandom_range(9997, 9999);
                2:       y = $urandom_range(1, 99) * 100 + $urandom_range(0, 2) - 1;
                default: y = $urandom_range(1, 9999);
            endcase
            m = $urandom_range(1, 12);
            d = $urandom_range(1, month_days(y, m));
        end else if (r < 95) begin
            y = $urandom_range(0, 16383);
            m = $urandom_range(0, 15);
            d = $urandom_range(0, 31);
        end else begin
            y = $urandom_range(1, 9999);
            m = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : $urandom_range(13, 15);
            if ($urandom_range(0, 3) == 0) m = 0;
            d = $urandom_range(0, 1) ? 0 : 31;
        end
        r = $urandom_range(0, 99);
        if (r == 0)
            off = int'($urandom_range(0, 65535)) - 32768;
        else if (r < 70)
            off = int'($urandom_range(0, 80)) - 40;
        else
            off = int'($urandom_range(0, 1600)) - 800;
        queue_request(y, m, d, off);
    endtask

    // Hold until every queued request is taken and every result has come back
    task automatic wait_drained();
        while (pending_requests.size() != 0 || s_tvalid || expected_dates.size() != 0)
            @(posedge aclk);
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Drive requests and the result ready at the falling edge
    always @(negedge aclk) begin : drive_requests
        logic          next_valid;
        date_request_t next_req;
        next_valid = s_tvalid;
        next_req   = date_request_t'(s_tdata[REQ_W-1:0]);
        if (aresetn) begin
            if (!s_tvalid || s_fired) begin
                next_valid = 1'b0;
                if (pending_requests.size() != 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct) begin
                    next_req   = pending_requests.pop_front();
                    next_valid = 1'b1;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
        s_tvalid <= next_valid;
        s_tdata  <= {{(S_DATA_W - REQ_W){1'b0}}, next_req};
    end

    // Predict the result of each accepted request
    always @(posedge aclk) begin
        s_fired <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            expected_dates = {expected_dates,
                              advance_date(date_request_t'(s_tdata[REQ_W-1:0]))};
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge aclk) begin : check_results
        date_result_t got;
        date_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = date_result_t'(m_tdata[RES_W-1:0]);
            if (expected_dates.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d-%0d-%0d",
                         $time, got.year, got.month, got.day);
                mismatch_count++;
            end else begin
                want = expected_dates.pop_front();
                check_field("end_year", want.year, got.year);
                check_field("end_month", want.month, got.month);
                check_field("end_day", want.day, got.day);
                check_field("weekday", want.weekday, got.weekday);
                check_field("year_clamped", want.clamped, got.clamped);
            end
        end
    end

    // Stop a run that hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 4 * cycle_budget + 50000) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        // Directed: leap rules, month and year wraps, bounds and malformed dates
        queue_request(2024, 2, 28, 1);
        queue_request(2023, 2, 28, 1);
        queue_request(1900, 2, 28, 1);
        queue_request(2000, 2, 29, 1);
        queue_request(2000, 3, 1, -1);
        queue_request(2021, 12, 31, 1);
        queue_request(2022, 1, 1, -1);
        queue_request(9999, 12, 31, 1);
        queue_request(9999, 12, 25, 32767);
        queue_request(1, 1, 1, -1);
        queue_request(1, 1, 5, -32768);
        queue_request(0, 6, 15, 0);
        queue_request(16383, 5, 20, 0);
        queue_request(2020, 0, 10, 3);
        queue_request(2020, 15, 30, 2);
        queue_request(2020, 5, 0, 1);
        queue_request(2020, 5, 0, -1);
        queue_request(2021, 4, 31, 0);
        queue_request(2021, 4, 31, 1);
        queue_request(2021, 2, 31, -1);
        queue_request(2000, 1, 1, 0);
        queue_request(1, 1, 1, 0);
        queue_request(1, 1, 1, 32767);
        queue_request(9999, 12, 31, -32768);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Phase with no idling on either side
        for (int i = 0; i < ITEMS_PER_PHASE; i++)
            queue_random_request();
        wait_drained();

        // Sender mostly idle
        sender_idle_pct = 82;
        recv_stall_pct  = 0;
        for (int i = 0; i < ITEMS_PER_PHASE; i++)
            queue_random_request();
        wait_drained();

        // Receiver mostly stalling
        sender_idle_pct = 0;
        recv_stall_pct  = 82;
        for (int i = 0; i < ITEMS_PER_PHASE; i++)
            queue_random_request();
        wait_drained();

        // Both sides idling part of the time
        sender_idle_pct = 36;
        recv_stall_pct  = 36;
        for (int i = 0; i < ITEMS_PER_PHASE; i++)
            queue_random_request();
        wait_drained();

        // Let any stray result surface
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_dates.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ----- gregorian_date_add_days.f -----
+incdir+src
src/gdad_pkg.sv
src/gdad_ctrl.sv
src/gdad_dp.sv
src/gregorian_date_add_days.sv
src/gdad_chk.sv
test/tb_top.sv
